// ===== rtl/core/fce_pkg.sv =====
// fce_pkg: shared types, codes and constants of the chain table engine.
// Depends on nothing; every other file of the block but fce_ram uses it.
package fce_pkg;

	localparam int TABLE_DEPTH_DEF = 4096;

	localparam int ACTION_W      = 3;
	localparam int ENTRY_W       = 16;
	localparam int SEQ_W         = 12;
	localparam int DATA_START_W  = 12;
	localparam int BLOCK_COUNT_W = 13;
	localparam int FREE_COUNT_W  = 13;
	localparam int STATUS_W      = 2;
	localparam int CFG_AW        = 3;
	localparam int CFG_DW        = 32;

	localparam logic [ENTRY_W-1:0] END_MARK = 16'hFFFF;

	localparam logic [ACTION_W-1:0] ACT_ALLOC  = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_FOLLOW = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_FREE   = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_COUNT  = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_TAIL   = 3'd4;
	localparam logic [ACTION_W-1:0] ACT_WRITE  = 3'd5;
	localparam logic [ACTION_W-1:0] ACT_READ   = 3'd6;

	localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NO_FREE    = 2'd1;
	localparam logic [STATUS_W-1:0] ST_WALK_LIMIT = 2'd2;

	// register selects (word address bit above the byte offset)
	localparam logic REG_DATA_START  = 1'b0;
	localparam logic REG_BLOCK_COUNT = 1'b1;

	localparam logic [DATA_START_W-1:0]  DATA_START_RST  = 12'd3;
	localparam logic [BLOCK_COUNT_W-1:0] BLOCK_COUNT_RST = 13'd4096;

	typedef struct packed {
		logic [DATA_START_W-1:0]  data_start;
		logic [BLOCK_COUNT_W-1:0] block_count;
	} cfg_t;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [ENTRY_W-1:0]  head_index;
		logic [ENTRY_W-1:0]  tail_index;
		logic [SEQ_W-1:0]    block_seq;
		logic [ENTRY_W-1:0]  entry_value;
	} req_t;

	typedef struct packed {
		logic [ENTRY_W-1:0]      result_index;
		logic [FREE_COUNT_W-1:0] free_count;
		logic [STATUS_W-1:0]     status;
	} rsp_t;

endpackage

// ===== rtl/core/fce_if.sv =====
// Request and result channels of the chain table engine (valid/ready).
// Depends on fce_pkg for field widths.
interface fce_req_if;
	logic                          valid;
	logic                          ready;
	logic [fce_pkg::ACTION_W-1:0] action;
	logic [fce_pkg::ENTRY_W-1:0]  head_index;
	logic [fce_pkg::ENTRY_W-1:0]  tail_index;
	logic [fce_pkg::SEQ_W-1:0]    block_seq;
	logic [fce_pkg::ENTRY_W-1:0]  entry_value;

	modport source (output valid, action, head_index, tail_index, block_seq, entry_value,
		input ready);
	modport sink (input valid, action, head_index, tail_index, block_seq, entry_value,
		output ready);
endinterface

interface fce_rsp_if;
	logic                              valid;
	logic                              ready;
	logic [fce_pkg::ENTRY_W-1:0]      result_index;
	logic [fce_pkg::FREE_COUNT_W-1:0] free_count;
	logic [fce_pkg::STATUS_W-1:0]     status;

	modport source (output valid, result_index, free_count, status, input ready);
	modport sink (input valid, result_index, free_count, status, output ready);
endinterface

// ===== rtl/core/fat_chain_table_engine.sv =====
// fat_chain_table_engine: 16-bit allocation table held in one read-first RAM.
// Operations: write or read one entry; follow, free or find the tail of a chain (a broken
// chain ends with a limit status after TABLE_DEPTH links); count the free blocks from
// data_start below min(block_count, TABLE_DEPTH); allocate the first free one there.
// One request at a time; the next is taken in the cycle after the result moves out.
// Reset: control clears at once, then a pass over every entry zeroes the table.
module fat_chain_table_engine #(
	parameter int TABLE_DEPTH = fce_pkg::TABLE_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [fce_pkg::CFG_AW-1:0] paddr,
	input  logic [fce_pkg::CFG_DW-1:0] pwdata,
	output logic [fce_pkg::CFG_DW-1:0] prdata,
	output logic                       pready,
	fce_req_if.sink                    req,
	fce_rsp_if.source                  rsp
);
	import fce_pkg::*;

	localparam int IDX_W = $clog2(TABLE_DEPTH);

	cfg_t               cfg;
	req_t               req_word;
	rsp_t               res_word;
	logic               res_valid;
	logic               res_ready;
	logic               ram_we;
	logic [IDX_W-1:0]   ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic [IDX_W-1:0]   ram_raddr;
	logic [ENTRY_W-1:0] ram_rdata;

	// output register: holds a finished word so the sequencer can take the next request
	logic               out_valid_q;
	rsp_t               out_word_q;

	// pack the request channel into one word
	assign req_word.action      = req.action;
	assign req_word.head_index  = req.head_index;
	assign req_word.tail_index  = req.tail_index;
	assign req_word.block_seq   = req.block_seq;
	assign req_word.entry_value = req.entry_value;

	fce_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	fce_seq #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.in_word   (req_word),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_word  (res_word),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	// the table itself: one entry per block, 0 free, all ones ends a chain
	fce_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// take a new word whenever the slot is empty or being drained this cycle
	assign res_ready = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// payload: load with the handshake, otherwise hold
	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_word_q <= res_word;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.result_index = out_word_q.result_index;
	assign rsp.free_count   = out_word_q.free_count;
	assign rsp.status       = out_word_q.status;
endmodule

// ===== rtl/core/fce_ram.sv =====
// fce_ram: generic simple dual-port RAM, one write and one registered read port.
// Read-first: a read of the entry written at the same edge returns the old word.
module fce_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/core/fce_cfg.sv =====
// fce_cfg: APB register file for data_start and block_count.
// Depends on fce_pkg (cfg_t, register selects, reset values).
module fce_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [fce_pkg::CFG_AW-1:0]   paddr,
	input  logic [fce_pkg::CFG_DW-1:0]   pwdata,
	output logic [fce_pkg::CFG_DW-1:0]   prdata,
	output logic                         pready,
	output fce_pkg::cfg_t                cfg
);
	import fce_pkg::*;

	logic reg_sel;
	logic wr_en;
	cfg_t cfg_q;

	assign reg_sel = paddr[CFG_AW-1];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.data_start  <= DATA_START_RST;
			cfg_q.block_count <= BLOCK_COUNT_RST;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_DATA_START:  cfg_q.data_start  <= pwdata[DATA_START_W-1:0];
				REG_BLOCK_COUNT: cfg_q.block_count <= pwdata[BLOCK_COUNT_W-1:0];
				default:         cfg_q.data_start  <= cfg_q.data_start;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_DATA_START:  prdata = CFG_DW'(cfg_q.data_start);
			REG_BLOCK_COUNT: prdata = CFG_DW'(cfg_q.block_count);
			default:         prdata = '0;
		endcase
	end
endmodule

// ===== rtl/core/fce_seq.sv =====
// fce_seq: sequencer that walks, scans and rewrites the table through one RAM.
// Depends on fce_pkg; drives the write and read ports of fce_ram.
module fce_seq #(
	parameter int TABLE_DEPTH = fce_pkg::TABLE_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  fce_pkg::cfg_t                  cfg,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  fce_pkg::req_t                  in_word,
	output logic                           res_valid,
	input  logic                           res_ready,
	output fce_pkg::rsp_t                  res_word,
	output logic                           ram_we,
	output logic [$clog2(TABLE_DEPTH)-1:0] ram_waddr,
	output logic [fce_pkg::ENTRY_W-1:0]    ram_wdata,
	output logic [$clog2(TABLE_DEPTH)-1:0] ram_raddr,
	input  logic [fce_pkg::ENTRY_W-1:0]    ram_rdata
);
	import fce_pkg::*;

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int LIM_W = $clog2(TABLE_DEPTH + 1);
	localparam int CMP_W = (LIM_W > SEQ_W) ? LIM_W : SEQ_W;
	localparam int LW    = (LIM_W > BLOCK_COUNT_W) ? LIM_W : BLOCK_COUNT_W;
	localparam logic [LIM_W-1:0]   DEPTH_L  = LIM_W'(TABLE_DEPTH);
	localparam logic [ENTRY_W-1:0] DEPTH_E  = ENTRY_W'(TABLE_DEPTH);
	localparam logic [IDX_W-1:0]   CLR_LAST = IDX_W'(TABLE_DEPTH - 1);

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_WALK  = 3'd2;
	localparam logic [2:0] S_SCAN  = 3'd3;
	localparam logic [2:0] S_MARK  = 3'd4;
	localparam logic [2:0] S_WRITE = 3'd5;
	localparam logic [2:0] S_DONE  = 3'd6;

	logic [2:0]          state_q;
	logic [ACTION_W-1:0] mode_q;
	logic [ENTRY_W-1:0]  cur_q;
	logic [ENTRY_W-1:0]  prev_q;
	logic [ENTRY_W-1:0]  tail_q;
	logic [ENTRY_W-1:0]  val_q;
	logic [SEQ_W-1:0]    seq_q;
	logic [LIM_W-1:0]    steps_q;
	logic                from_ram_q;
	logic                oob_q;
	logic [LIM_W-1:0]    addr_q;
	logic [LIM_W-1:0]    lim_q;
	logic [LIM_W-1:0]    cnt_q;
	logic [IDX_W-1:0]    clr_q;
	logic [IDX_W-1:0]    found_q;
	logic                rd_valid_s1;
	logic [IDX_W-1:0]    rd_idx_s1;
	rsp_t                res_q;

	logic [LW-1:0]       lim_wide;
	logic [LIM_W-1:0]    lim_w;
	logic                start_below;
	logic [ENTRY_W-1:0]  cur;
	logic                cur_in;
	logic                at_limit;
	logic                more_links;
	logic                scan_hit;
	logic                scan_issue;
	logic [ENTRY_W-1:0]  walk_res;

	assign lim_wide    = (LW'(cfg.block_count) < LW'(TABLE_DEPTH)) ?
		LW'(cfg.block_count) : LW'(TABLE_DEPTH);
	assign lim_w       = lim_wide[LIM_W-1:0];
	assign start_below = LW'(cfg.data_start) < lim_wide;

	// link in hand: the head on the first step, then the word just read back
	assign cur        = from_ram_q ? (oob_q ? END_MARK : ram_rdata) : cur_q;
	assign cur_in     = cur < DEPTH_E;
	assign at_limit   = steps_q >= DEPTH_L;
	assign more_links = CMP_W'(steps_q) < CMP_W'(seq_q);
	assign scan_hit   = rd_valid_s1 && (ram_rdata == '0);
	assign scan_issue = addr_q < lim_q;
	assign walk_res   = (mode_q == ACT_TAIL) ? prev_q :
		((mode_q == ACT_FOLLOW) ? cur : '0);

	assign in_ready  = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res_word  = res_q;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_raddr = '0;
		unique case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
			end
			S_WALK: begin
				ram_raddr = cur[IDX_W-1:0];
				if (mode_q == ACT_FREE && cur != END_MARK && !at_limit && cur_in) begin
					ram_we    = 1'b1;
					ram_waddr = cur[IDX_W-1:0];
				end
			end
			S_SCAN: begin
				ram_raddr = addr_q[IDX_W-1:0];
				if (scan_hit && mode_q == ACT_ALLOC && tail_q < DEPTH_E) begin
					ram_we    = 1'b1;
					ram_waddr = tail_q[IDX_W-1:0];
					ram_wdata = ENTRY_W'(rd_idx_s1);
				end
			end
			S_MARK: begin
				ram_we    = 1'b1;
				ram_waddr = found_q;
				ram_wdata = END_MARK;
			end
			S_WRITE: begin
				if (cur_q < DEPTH_E) begin
					ram_we    = 1'b1;
					ram_waddr = cur_q[IDX_W-1:0];
					ram_wdata = val_q;
				end
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			rd_valid_s1 <= 1'b0;
			from_ram_q  <= 1'b0;
			oob_q       <= 1'b0;
			steps_q     <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CLR_LAST) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						mode_q      <= (in_word.action == ACT_READ) ? ACT_FOLLOW : in_word.action;
						seq_q       <= (in_word.action == ACT_READ) ? SEQ_W'(1) : in_word.block_seq;
						cur_q       <= in_word.head_index;
						prev_q      <= in_word.head_index;
						tail_q      <= in_word.tail_index;
						val_q       <= in_word.entry_value;
						steps_q     <= '0;
						from_ram_q  <= 1'b0;
						oob_q       <= 1'b0;
						cnt_q       <= '0;
						rd_valid_s1 <= 1'b0;
						lim_q       <= lim_w;
						addr_q      <= start_below ? LIM_W'(cfg.data_start) : lim_w;
						res_q       <= '0;
						unique case (in_word.action)
							ACT_ALLOC, ACT_COUNT:                     state_q <= S_SCAN;
							ACT_FOLLOW, ACT_FREE, ACT_TAIL, ACT_READ: state_q <= S_WALK;
							ACT_WRITE:                                state_q <= S_WRITE;
							default:                                  state_q <= S_DONE;
						endcase
					end
				end
				S_WALK: begin
					if (cur == END_MARK || (mode_q == ACT_FOLLOW && !more_links)) begin
						res_q.result_index <= walk_res;
						res_q.status       <= ST_OK;
						state_q            <= S_DONE;
					end else if (at_limit) begin
						res_q.result_index <= walk_res;
						res_q.status       <= ST_WALK_LIMIT;
						state_q            <= S_DONE;
					end else begin
						prev_q     <= cur;
						oob_q      <= !cur_in;
						from_ram_q <= 1'b1;
						steps_q    <= steps_q + 1'b1;
					end
				end
				S_SCAN: begin
					rd_valid_s1 <= scan_issue;
					rd_idx_s1   <= addr_q[IDX_W-1:0];
					if (scan_issue) begin
						addr_q <= addr_q + 1'b1;
					end
					if (scan_hit && mode_q == ACT_ALLOC) begin
						found_q     <= rd_idx_s1;
						rd_valid_s1 <= 1'b0;
						state_q     <= S_MARK;
					end else begin
						if (scan_hit) begin
							cnt_q <= cnt_q + 1'b1;
						end
						if (!scan_issue && !rd_valid_s1) begin
							if (mode_q == ACT_ALLOC) begin
								res_q.result_index <= END_MARK;
								res_q.status       <= ST_NO_FREE;
							end else begin
								res_q.free_count <= FREE_COUNT_W'(cnt_q);
							end
							state_q <= S_DONE;
						end
					end
				end
				S_MARK: begin
					res_q.result_index <= ENTRY_W'(found_q);
					res_q.status       <= ST_OK;
					state_q            <= S_DONE;
				end
				S_WRITE: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_steps_bound: assert property (@(posedge clk) disable iff (!arst_n)
		steps_q <= DEPTH_L)
		else $error("walk step count ran past the table depth");

	a_hit_marks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && scan_hit && mode_q == ACT_ALLOC) |=> (state_q == S_MARK))
		else $error("allocation hit did not mark the new block");

	a_walk_write: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && state_q == S_WALK) |-> (mode_q == ACT_FREE && ram_waddr == cur[IDX_W-1:0]))
		else $error("table written during a walk that frees nothing");

	a_scan_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		rd_valid_s1 |-> (state_q == S_SCAN))
		else $error("scan read pending outside the scan");
`endif
endmodule
